// File: src/hcw_pkg.sv
package hcw_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_POP
   } state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [2:0] phase;
   } frame_type;

   localparam logic [1:0] REG_CURVE_ORDER = 2'd0;
   localparam logic [1:0] REG_STEP_SIZE   = 2'd1;
   localparam logic [1:0] REG_START_X     = 2'd2;
   localparam logic [1:0] REG_START_Y     = 2'd3;

   localparam logic [1:0] KIND_A = 2'd0;
   localparam logic [1:0] KIND_B = 2'd1;
   localparam logic [1:0] KIND_C = 2'd2;
   localparam logic [1:0] KIND_D = 2'd3;

   localparam logic [2:0] PHASE_FIRST  = 3'd0;
   localparam logic [2:0] PHASE_MOVE2  = 3'd3;
   localparam logic [2:0] PHASE_MOVE3  = 3'd5;
   localparam logic [2:0] PHASE_SECOND = 3'd6;
   localparam logic [2:0] PHASE_DONE   = 3'd7;

   function automatic logic kind_xmajor(input logic [1:0] kind);
      logic r;
      unique case (kind)
         KIND_A:  r = 1'b1;
         KIND_B:  r = 1'b0;
         KIND_C:  r = 1'b1;
         KIND_D:  r = 1'b0;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic kind_neg(input logic [1:0] kind);
      logic r;
      unique case (kind)
         KIND_A:  r = 1'b0;
         KIND_B:  r = 1'b1;
         KIND_C:  r = 1'b1;
         KIND_D:  r = 1'b0;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] kind_first(input logic [1:0] kind);
      logic [1:0] r;
      unique case (kind)
         KIND_A:  r = KIND_D;
         KIND_B:  r = KIND_C;
         KIND_C:  r = KIND_B;
         KIND_D:  r = KIND_A;
         default: r = KIND_A;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] kind_second(input logic [1:0] kind);
      logic [1:0] r;
      unique case (kind)
         KIND_A:  r = KIND_B;
         KIND_B:  r = KIND_A;
         KIND_C:  r = KIND_D;
         KIND_D:  r = KIND_C;
         default: r = KIND_A;
      endcase
      return r;
   endfunction

endpackage

// File: src/hcw_ram.sv
module hcw_ram #(
   parameter int WIDTH = 5,
   parameter int DEPTH = 8
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/hilbert_curve_walker.sv
// Hilbert curve walker. A request with restart set loads start_x/start_y, begins a curve of
// curve_order levels (capped at MAX_ORDER) and gives no response. A request with restart
// clear yields the next move: the new position (wrapping at COORD_BITS), whether x equals y
// there, a saturating count of such points kept until reset, and a mark on the final move;
// it gives no response when no curve is being walked. The curve's frames live on a stack in
// a small RAM with the top frame held in registers. After a request is taken, the top frame
// is worked in ST_STEP: a descent pushes it to the RAM, a phase step advances it, and an
// unwind passes through ST_POP for the RAM read of the parent frame. Every move follows at
// least one call step, and a waiting response holds the move. One request is worked on at a
// time; the next request is taken while a response still waits in the output register.
module hilbert_curve_walker #(
   parameter int MAX_ORDER  = 8,
   parameter int COORD_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_restart,

   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic               rsp_on_diagonal,
   output logic [15:0]        rsp_diagonal_count,
   output logic               rsp_last_move,

   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [3:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready
);

   import hcw_pkg::*;

   localparam int AW         = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
   localparam int LOOP_BOUND = 4 * MAX_ORDER + 8;
   localparam int IT_W       = $clog2(LOOP_BOUND + 1);

   // configuration registers
   logic [3:0]        curve_order_ff;
   logic [8:0]        step_size_ff;
   logic signed [15:0] start_x_ff;
   logic signed [15:0] start_y_ff;
   logic              csr_write;

   // walker state
   state_type            state_ff, state_in;
   frame_type            frame_ff, frame_in;
   logic [AW-1:0]        top_ff, top_in;
   logic [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic [15:0]          diag_ff, diag_in;
   logic                 walking_ff, walking_in;
   logic [IT_W-1:0]      iter_ff, iter_in;
   logic [MAX_ORDER-1:0] ph6_ff, ph6_in;

   // response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [15:0]          rsp_x_ff, rsp_x_in;
   logic [15:0]          rsp_y_ff, rsp_y_in;
   logic                 rsp_diag_ff, rsp_diag_in;
   logic [15:0]          rsp_count_ff, rsp_count_in;
   logic                 rsp_last_ff, rsp_last_in;

   // frame stack memory
   logic                 mem_we;
   logic [AW-1:0]        mem_waddr;
   frame_type            mem_wdata;
   logic [AW-1:0]        mem_raddr;
   frame_type            mem_rdata;

   // decode
   logic                 req_take;
   logic [3:0]           order_eff;
   logic [4:0]           ord5;
   logic [4:0]           top5;
   logic                 pop_cond;
   logic                 leaf_cond;
   logic                 is_move;
   logic                 out_free;
   logic                 iter_end;
   logic                 all_below6;
   logic [MAX_ORDER-1:0] below;
   logic                 on_x;
   logic                 sub;
   logic [31:0]          amt32;
   logic [COORD_BITS-1:0] amt;
   logic [COORD_BITS-1:0] sel_c;
   logic [COORD_BITS-1:0] new_c;
   logic [COORD_BITS-1:0] new_x;
   logic [COORD_BITS-1:0] new_y;
   logic [31:0]          x32;
   logic [31:0]          y32;
   logic signed [31:0]   sx32;
   logic signed [31:0]   sy32;
   logic                 diag_hit;
   logic                 last_hit;
   logic [1:0]           child;

   hcw_ram #(
      .WIDTH($bits(frame_type)),
      .DEPTH(MAX_ORDER)
   ) u_stack (
      .clock  (clock),
      .wr_en  (mem_we),
      .wr_addr(mem_waddr),
      .wr_data(mem_wdata),
      .rd_addr(mem_raddr),
      .rd_data(mem_rdata)
   );

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_order_ff <= 4'd3;
         step_size_ff   <= 9'd1;
         start_x_ff     <= '0;
         start_y_ff     <= '0;
      end else if (csr_write) begin
         unique case (csr_paddr[3:2])
            REG_CURVE_ORDER: curve_order_ff <= csr_pwdata[3:0];
            REG_STEP_SIZE:   step_size_ff   <= csr_pwdata[8:0];
            REG_START_X:     start_x_ff     <= csr_pwdata[15:0];
            REG_START_Y:     start_y_ff     <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_CURVE_ORDER: csr_prdata = 32'(curve_order_ff);
         REG_STEP_SIZE:   csr_prdata = 32'(step_size_ff);
         REG_START_X:     csr_prdata = 32'(unsigned'(start_x_ff));
         REG_START_Y:     csr_prdata = 32'(unsigned'(start_y_ff));
         default:         csr_prdata = '0;
      endcase
   end

   // decode of the top frame
   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign order_eff = (curve_order_ff > 4'(MAX_ORDER)) ? 4'(MAX_ORDER) : curve_order_ff;
   assign ord5      = 5'(order_eff);
   assign top5      = 5'(top_ff);
   assign pop_cond  = (ord5 <= top5) || (frame_ff.phase == PHASE_DONE);
   assign leaf_cond = (ord5 <= top5 + 5'd1) || (top5 + 5'd1 >= 5'(MAX_ORDER));
   assign is_move   = frame_ff.phase[0];
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign iter_end  = (iter_ff >= IT_W'(LOOP_BOUND));

   always_comb begin
      for (int k = 0; k < MAX_ORDER; k++) begin
         below[k] = (k < int'(top_ff));
      end
   end
   assign all_below6 = &(ph6_ff | ~below);

   always_comb begin
      if (frame_ff.phase == PHASE_FIRST) begin
         child = kind_first(frame_ff.kind);
      end else if (frame_ff.phase == PHASE_SECOND) begin
         child = kind_second(frame_ff.kind);
      end else begin
         child = frame_ff.kind;
      end
   end

   // move arithmetic
   assign on_x  = (frame_ff.phase == PHASE_MOVE2) ? !kind_xmajor(frame_ff.kind)
                                                  : kind_xmajor(frame_ff.kind);
   assign sub   = (frame_ff.phase != PHASE_MOVE3) ^ kind_neg(frame_ff.kind);
   assign amt32 = 32'(step_size_ff);
   assign amt   = amt32[COORD_BITS-1:0];
   assign sel_c = on_x ? cur_x_ff : cur_y_ff;
   assign new_c = sub ? (sel_c - amt) : (sel_c + amt);
   assign new_x = on_x ? new_c : cur_x_ff;
   assign new_y = on_x ? cur_y_ff : new_c;
   assign x32   = 32'(new_x);
   assign y32   = 32'(new_y);
   assign sx32  = 32'(start_x_ff);
   assign sy32  = 32'(start_y_ff);
   assign diag_hit = (new_x == new_y);
   assign last_hit = (frame_ff.phase == PHASE_MOVE3) && (ord5 == top5 + 5'd1) && all_below6;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && !req_restart && walking_ff) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            priority if (iter_end) begin
               state_in = ST_IDLE;
            end else if (pop_cond) begin
               state_in = (top_ff == '0) ? ST_IDLE : ST_POP;
            end else if (is_move) begin
               if (out_free) begin
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_STEP;
            end
         end
         ST_POP: begin
            state_in = ST_STEP;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      frame_in     = frame_ff;
      top_in       = top_ff;
      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      diag_in      = diag_ff;
      walking_in   = walking_ff;
      iter_in      = iter_ff;
      ph6_in       = ph6_ff;
      mem_we       = 1'b0;
      mem_waddr    = top_ff;
      mem_wdata    = frame_ff;
      mem_raddr    = top_ff - AW'(1);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_diag_in  = rsp_diag_ff;
      rsp_count_in = rsp_count_ff;
      rsp_last_in  = rsp_last_ff;
      unique case (state_ff)
         ST_IDLE: begin
            iter_in = '0;
            if (req_take && req_restart) begin
               cur_x_in   = sx32[COORD_BITS-1:0];
               cur_y_in   = sy32[COORD_BITS-1:0];
               top_in     = '0;
               frame_in   = '{kind: KIND_A, phase: PHASE_FIRST};
               walking_in = (order_eff != 4'd0);
            end
         end
         ST_STEP: begin
            priority if (iter_end) begin
               walking_in = 1'b0;
            end else if (pop_cond) begin
               iter_in = iter_ff + IT_W'(1);
               if (top_ff == '0) begin
                  walking_in = 1'b0;
               end
            end else if (is_move) begin
               if (out_free) begin
                  cur_x_in       = new_x;
                  cur_y_in       = new_y;
                  frame_in.phase = frame_ff.phase + 3'd1;
                  if (diag_hit && diag_ff != 16'hFFFF) begin
                     diag_in = diag_ff + 16'd1;
                  end
                  if (last_hit) begin
                     walking_in = 1'b0;
                  end
                  rsp_valid_in = 1'b1;
                  rsp_x_in     = x32[15:0];
                  rsp_y_in     = y32[15:0];
                  rsp_diag_in  = diag_hit;
                  rsp_count_in = (diag_hit && diag_ff != 16'hFFFF) ? diag_ff + 16'd1 : diag_ff;
                  rsp_last_in  = last_hit;
               end
            end else begin
               iter_in = iter_ff + IT_W'(1);
               if (leaf_cond) begin
                  frame_in.phase = frame_ff.phase + 3'd1;
               end else begin
                  mem_we         = 1'b1;
                  ph6_in[top_ff] = (frame_ff.phase == PHASE_SECOND);
                  top_in         = top_ff + AW'(1);
                  frame_in       = '{kind: child, phase: PHASE_FIRST};
               end
            end
         end
         ST_POP: begin
            top_in   = top_ff - AW'(1);
            frame_in = '{kind: mem_rdata.kind, phase: mem_rdata.phase + 3'd1};
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         frame_ff     <= '0;
         top_ff       <= '0;
         cur_x_ff     <= '0;
         cur_y_ff     <= '0;
         diag_ff      <= '0;
         walking_ff   <= 1'b0;
         iter_ff      <= '0;
         ph6_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         frame_ff     <= frame_in;
         top_ff       <= top_in;
         cur_x_ff     <= cur_x_in;
         cur_y_ff     <= cur_y_in;
         diag_ff      <= diag_in;
         walking_ff   <= walking_in;
         iter_ff      <= iter_in;
         ph6_ff       <= ph6_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_x_ff     <= rsp_x_in;
      rsp_y_ff     <= rsp_y_in;
      rsp_diag_ff  <= rsp_diag_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pos_x          = rsp_x_ff;
   assign rsp_pos_y          = rsp_y_ff;
   assign rsp_on_diagonal    = rsp_diag_ff;
   assign rsp_diagonal_count = rsp_count_ff;
   assign rsp_last_move      = rsp_last_ff;

   a_top_in_range: assert property (@(posedge clock) disable iff (reset)
      32'(top_ff) < MAX_ORDER)
      else $error("stack level beyond depth");

   a_pop_not_root: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_POP |-> top_ff != '0)
      else $error("unwind from root frame");

   a_rsp_from_step: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_STEP)
      else $error("response without a move");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) && rsp_last_ff |-> !walking_ff)
      else $error("walker still active after final move");

endmodule

// File: bench/tb_hilbert_curve_walker.sv
`timescale 1ns / 1ps

module tb_hilbert_curve_walker;
   import hcw_pkg::*;

   localparam int MAX_LEVELS    = 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int RANDOM_ITEMS  = 400;

   typedef struct packed {
      logic signed [15:0] x;
      logic signed [15:0] y;
      logic               diag;
      logic [15:0]        count;
      logic               last;
   } hilbert_move_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic               req_valid = 1'b0;
   logic               req_restart = 1'b0;
   logic               req_stall;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [15:0] rsp_pos_x;
   logic signed [15:0] rsp_pos_y;
   logic               rsp_on_diagonal;
   logic [15:0]        rsp_diagonal_count;
   logic               rsp_last_move;
   logic               csr_psel = 1'b0;
   logic               csr_penable = 1'b0;
   logic               csr_pwrite = 1'b0;
   logic [3:0]         csr_paddr = '0;
   logic [31:0]        csr_pwdata = '0;
   logic [31:0]        csr_prdata;
   logic               csr_pready;

   hilbert_curve_walker dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_restart        (req_restart),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_pos_x          (rsp_pos_x),
      .rsp_pos_y          (rsp_pos_y),
      .rsp_on_diagonal    (rsp_on_diagonal),
      .rsp_diagonal_count (rsp_diagonal_count),
      .rsp_last_move      (rsp_last_move),
      .csr_psel           (csr_psel),
      .csr_penable        (csr_penable),
      .csr_pwrite         (csr_pwrite),
      .csr_paddr          (csr_paddr),
      .csr_pwdata         (csr_pwdata),
      .csr_prdata         (csr_prdata),
      .csr_pready         (csr_pready)
   );

   // walker state as the predictor sees it
   logic [1:0]  fr_kind [0:MAX_LEVELS-1];
   logic [2:0]  fr_phase [0:MAX_LEVELS-1];
   int          depth_ptr;
   logic [15:0] pen_x;
   logic [15:0] pen_y;
   logic [15:0] diag_seen;
   bit          walking_now;
   logic [3:0]  order_reg;
   logic [8:0]  step_reg;
   logic [15:0] sx_reg;
   logic [15:0] sy_reg;

   hilbert_move_type pending_moves [$];

   int idle_pct = 0;
   int stall_pct = 0;
   int mismatches = 0;
   int n_requests = 0;
   int n_checked = 0;
   int n_last = 0;
   int n_diag = 0;
   longint cycles = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("tb_hilbert_curve_walker failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
   end

   function automatic bit next_move(input bit restart, output hilbert_move_type mv);
      int lvl_cap;
      int top;
      int lvl;
      int it;
      int k;
      logic [2:0] ph;
      logic [1:0] ty;
      logic [1:0] child;
      bit on_x;
      bit sub;
      bit fin;
      bit xmaj;
      bit neg;
      logic [15:0] amt;
      mv = '0;
      lvl_cap = (order_reg > MAX_LEVELS) ? MAX_LEVELS : int'(order_reg);
      if (restart) begin
         pen_x = sx_reg;
         pen_y = sy_reg;
         depth_ptr = 0;
         fr_kind[0] = KIND_A;
         fr_phase[0] = PHASE_FIRST;
         walking_now = lvl_cap > 0;
         return 1'b0;
      end
      if (!walking_now) return 1'b0;
      for (it = 0; it < 4 * MAX_LEVELS + 8; it++) begin
         top = depth_ptr;
         if (top >= MAX_LEVELS) begin
            walking_now = 1'b0;
            return 1'b0;
         end
         lvl = lvl_cap - top;
         ph = fr_phase[top];
         ty = fr_kind[top];
         if (lvl <= 0 || ph == PHASE_DONE) begin
            if (top == 0) begin
               walking_now = 1'b0;
               return 1'b0;
            end
            depth_ptr = top - 1;
            fr_phase[top-1] = fr_phase[top-1] + 3'd1;
            continue;
         end
         if (!ph[0]) begin
            child = ty;
            if (ph == PHASE_FIRST) begin
               case (ty)
                  KIND_A:  child = KIND_D;
                  KIND_B:  child = KIND_C;
                  KIND_C:  child = KIND_B;
                  default: child = KIND_A;
               endcase
            end else if (ph == PHASE_SECOND) begin
               case (ty)
                  KIND_A:  child = KIND_B;
                  KIND_B:  child = KIND_A;
                  KIND_C:  child = KIND_D;
                  default: child = KIND_C;
               endcase
            end
            if (lvl - 1 <= 0 || top + 1 >= MAX_LEVELS) begin
               fr_phase[top] = ph + 3'd1;
            end else begin
               depth_ptr = top + 1;
               fr_kind[top+1] = child;
               fr_phase[top+1] = PHASE_FIRST;
            end
            continue;
         end
         xmaj = (ty == KIND_A) || (ty == KIND_C);
         neg = (ty == KIND_B) || (ty == KIND_C);
         on_x = (ph == PHASE_MOVE2) ? !xmaj : xmaj;
         sub = (ph != PHASE_MOVE3) != neg;
         amt = {7'd0, step_reg};
         if (on_x) pen_x = sub ? pen_x - amt : pen_x + amt;
         else pen_y = sub ? pen_y - amt : pen_y + amt;
         fr_phase[top] = ph + 3'd1;
         mv.diag = (pen_x == pen_y);
         if (mv.diag && diag_seen != 16'hFFFF) diag_seen++;
         fin = (ph == PHASE_MOVE3) && (lvl == 1);
         for (k = 0; k < top; k++) begin
            if (fr_phase[k] != PHASE_SECOND) fin = 1'b0;
         end
         if (fin) walking_now = 1'b0;
         mv.x = pen_x;
         mv.y = pen_y;
         mv.count = diag_seen;
         mv.last = fin;
         return 1'b1;
      end
      walking_now = 1'b0;
      return 1'b0;
   endfunction

   always @(posedge clock) begin : check_rsp
      hilbert_move_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_moves.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected move: x=%0d y=%0d diag=%0b count=%0d last=%0b",
                        rsp_pos_x, rsp_pos_y, rsp_on_diagonal, rsp_diagonal_count,
                        rsp_last_move);
         end else begin
            want = pending_moves.pop_front();
            if (rsp_pos_x !== want.x || rsp_pos_y !== want.y ||
                rsp_on_diagonal !== want.diag || rsp_diagonal_count !== want.count ||
                rsp_last_move !== want.last) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("move %0d expected: x=%0d y=%0d diag=%0b count=%0d last=%0b",
                           n_checked, want.x, want.y, want.diag, want.count, want.last);
                  $display("move %0d actual:   x=%0d y=%0d diag=%0b count=%0d last=%0b",
                           n_checked, rsp_pos_x, rsp_pos_y, rsp_on_diagonal,
                           rsp_diagonal_count, rsp_last_move);
               end
            end
            n_checked++;
            if (want.last) n_last++;
            if (want.diag) n_diag++;
         end
      end
   end

   task automatic send_request(input bit restart);
      hilbert_move_type mv;
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         req_restart <= $urandom_range(1);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_restart <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (next_move(restart, mv)) pending_moves.push_back(mv);
      n_requests++;
   endtask

   // hold off until every move is back and the walker has had time to finish
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_moves.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      case (idx)
         REG_CURVE_ORDER: order_reg = value[3:0];
         REG_STEP_SIZE:   step_reg = value[8:0];
         REG_START_X:     sx_reg = value[15:0];
         default:         sy_reg = value[15:0];
      endcase
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic configure(input logic [31:0] ord, input logic [31:0] stp,
                            input logic [31:0] sx, input logic [31:0] sy);
      settle();
      csr_write(REG_CURVE_ORDER, ord);
      csr_write(REG_STEP_SIZE, stp);
      csr_write(REG_START_X, sx);
      csr_write(REG_START_Y, sy);
   endtask

   task automatic test_idle_advance();
      send_request(1'b0);
      send_request(1'b0);
   endtask

   task automatic test_small_curve();
      configure(1, 1, 0, 0);
      send_request(1'b1);
      repeat (4) send_request(1'b0);
   endtask

   task automatic test_order_zero();
      configure(0, 1, 5, 5);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   task automatic test_extreme_values();
      configure(1, 256, 16'h8000, 16'h7FFF);
      send_request(1'b1);
      repeat (3) send_request(1'b0);
      configure(1, 511, 16'hFFFF, 16'h0000);
      send_request(1'b1);
      send_request(1'b0);
   endtask

   task automatic test_order_clamp();
      configure(15, 3, 16'h0100, 16'hFF00);
      send_request(1'b1);
      repeat (2) send_request(1'b0);
   endtask

   task automatic test_order_change();
      configure(2, 2, 0, 0);
      send_request(1'b1);
      repeat (4) send_request(1'b0);
      settle();
      csr_write(REG_CURVE_ORDER, 1);
      repeat (2) send_request(1'b0);
      settle();
      csr_write(REG_CURVE_ORDER, 3);
      send_request(1'b0);
   endtask

   task automatic random_curve();
      logic [31:0] ord;
      logic [31:0] stp;
      logic [31:0] sx;
      logic [31:0] sy;
      int r;
      int moves;
      int n;
      int cut;
      int i;
      r = $urandom_range(99);
      if (r < 45) ord = $urandom_range(1, 2);
      else if (r < 80) ord = 3;
      else if (r < 88) ord = 4;
      else if (r < 91) ord = 0;
      else if (r < 94) ord = $urandom_range(9, 15);
      else ord = $urandom_range(5, 8);
      r = $urandom_range(99);
      if (r < 90) stp = $urandom_range(1, 256);
      else if (r < 95) stp = 0;
      else stp = $urandom_range(257, 511);
      sx = $urandom;
      sy = $urandom;
      r = $urandom_range(99);
      if (r < 10) sy = sx;
      else if (r < 20) begin
         sx[15:0] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
         sy[15:0] = $urandom_range(1) ? 16'hFFFF : 16'h0000;
      end
      moves = (ord == 0) ? 0 : (1 << (2 * ((ord > MAX_LEVELS) ? MAX_LEVELS : ord))) - 1;
      if (moves <= 150 && $urandom_range(99) < 60) n = moves + $urandom_range(2);
      else n = $urandom_range(0, (moves + 2 > 150) ? 150 : moves + 2);
      configure(ord | ($urandom & 32'hFFFF_FFF0), stp | ($urandom & 32'hFFFF_FE00), sx, sy);
      send_request(1'b1);
      cut = ($urandom_range(9) == 0) ? $urandom_range(0, n) : -1;
      for (i = 0; i < n; i++) begin
         if (i == cut) begin
            if ($urandom_range(1)) send_request(1'b1);
            else begin
               settle();
               csr_write(REG_CURVE_ORDER, $urandom_range(0, 9));
            end
         end
         if ($urandom_range(99) < 3) settle();
         send_request(1'b0);
      end
   endtask

   task automatic test_random_walks(input int gap_pct, input int hold_pct);
      int first;
      idle_pct = gap_pct;
      stall_pct = hold_pct;
      first = n_requests;
      while (n_requests - first < RANDOM_ITEMS) random_curve();
      settle();
   endtask

   // a top-order curve with zero step sits on the diagonal at every move
   task automatic test_zero_step_diagonal();
      idle_pct = 0;
      stall_pct = 0;
      configure(8, 0, 16'h1234, 16'h1234);
      send_request(1'b1);
      repeat (60) send_request(1'b0);
   endtask

   initial begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
         fr_kind[i] = KIND_A;
         fr_phase[i] = PHASE_FIRST;
      end
      depth_ptr = 0;
      pen_x = '0;
      pen_y = '0;
      diag_seen = '0;
      walking_now = 1'b0;
      order_reg = 4'd3;
      step_reg = 9'd1;
      sx_reg = '0;
      sy_reg = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_idle_advance();
      test_small_curve();
      test_order_zero();
      test_extreme_values();
      test_order_clamp();
      test_order_change();
      test_random_walks(0, 0);
      test_random_walks(77, 0);
      test_random_walks(0, 77);
      test_random_walks(23, 23);
      test_zero_step_diagonal();
      settle();

      $display("%0d requests over curve orders 0 to 15, four gap and stall mixes",
               n_requests);
      $display("%0d moves checked, %0d curve ends, %0d points on the diagonal",
               n_checked, n_last, n_diag);
      if (mismatches == 0 && pending_moves.size() == 0) begin
         $display("tb_hilbert_curve_walker passed");
      end else begin
         $display("%0d mismatches, %0d moves never seen", mismatches, pending_moves.size());
         $display("tb_hilbert_curve_walker failed");
      end
      $finish;
   end

endmodule
